### hdl/i2cm_pkg.sv
// Shared types, codes and constants for the I2C master bit engine.
package i2cm_pkg;

  // Command codes on the func field
  localparam logic [2:0] FUNC_TICK  = 3'd0;
  localparam logic [2:0] FUNC_START = 3'd1;
  localparam logic [2:0] FUNC_STOP  = 3'd2;
  localparam logic [2:0] FUNC_WRITE = 3'd3;
  localparam logic [2:0] FUNC_READ  = 3'd4;

  // Classified operation kinds handed from front to back
  localparam logic [2:0] KIND_TICK  = 3'd0;
  localparam logic [2:0] KIND_START = 3'd1;
  localparam logic [2:0] KIND_STOP  = 3'd2;
  localparam logic [2:0] KIND_WRITE = 3'd3;
  localparam logic [2:0] KIND_READ  = 3'd4;

  // Configuration register indexes
  localparam logic REG_PHASE_TICKS = 1'b0;
  localparam logic REG_ACK_TIMEOUT = 1'b1;

  localparam logic [7:0] PHASE_TICKS_RST = 8'd4;
  localparam logic [7:0] ACK_TIMEOUT_RST = 8'd250;

  localparam int QUEUE_DEPTH_DEF = 2;

  typedef struct packed {
    logic [2:0] func;
    logic [7:0] data_byte;
    logic       send_ack;
    logic       sda_in;
  } cmd_item_t;

  typedef struct packed {
    logic       scl;
    logic       sda;
    logic       busy_res;
    logic       done_res;
    logic       ack_error;
    logic [7:0] rx_byte;
  } res_item_t;

  typedef struct packed {
    logic [2:0] kind;
    logic [7:0] data_byte;
    logic       send_ack;
    logic       sda_in;
  } op_item_t;

  typedef struct packed {
    logic [7:0] phase_ticks;
    logic [7:0] ack_timeout;
  } cfg_t;

endpackage

### hdl/i2cm_fifo.sv
// Small register FIFO with first-word fall-through read.
module i2cm_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] wdata,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] rdata,
  output logic             empty
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [AW-1:0] LAST = AW'(DEPTH - 1);
  localparam logic [CW-1:0] FULL_COUNT = CW'(DEPTH);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [AW-1:0]    wr_ptr;
  logic [AW-1:0]    rd_ptr;
  logic [CW-1:0]    count;
  logic             do_push;
  logic             do_pop;

  assign full    = (count == FULL_COUNT);
  assign empty   = (count == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rdata   = mem[rd_ptr];

  // Store the incoming beat
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= wdata;
    end
  end

  // Advance pointers and occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == LAST) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == LAST) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

### hdl/i2cm_front.sv
// Front end: classify incoming beats into engine operations.
module i2cm_front
  import i2cm_pkg::*;
(
  input  cmd_item_t cmd,
  output op_item_t  op
);

  // Map func codes to kinds; unknown codes act as plain ticks
  always_comb begin
    op.data_byte = cmd.data_byte;
    op.send_ack  = cmd.send_ack;
    op.sda_in    = cmd.sda_in;
    case (cmd.func)
      FUNC_START: op.kind = KIND_START;
      FUNC_STOP:  op.kind = KIND_STOP;
      FUNC_WRITE: op.kind = KIND_WRITE;
      FUNC_READ:  op.kind = KIND_READ;
      FUNC_TICK:  op.kind = KIND_TICK;
      default:    op.kind = KIND_TICK;
    endcase
  end

endmodule

### hdl/i2cm_engine.sv
// Back end: bus phase sequencer that drives SCL/SDA one tick at a time.
module i2cm_engine
  import i2cm_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  cfg_t      cfg,
  input  logic      step,
  input  op_item_t  op,
  output res_item_t res
);

  localparam logic [4:0] PH_IDLE = 5'd0;
  localparam logic [4:0] PH_ST0  = 5'd1;
  localparam logic [4:0] PH_ST1  = 5'd2;
  localparam logic [4:0] PH_ST2  = 5'd3;
  localparam logic [4:0] PH_SP0  = 5'd4;
  localparam logic [4:0] PH_SP1  = 5'd5;
  localparam logic [4:0] PH_SP2  = 5'd6;
  localparam logic [4:0] PH_ESP0 = 5'd7;
  localparam logic [4:0] PH_ESP1 = 5'd8;
  localparam logic [4:0] PH_ESP2 = 5'd9;
  localparam logic [4:0] PH_WLO  = 5'd10;
  localparam logic [4:0] PH_WHI  = 5'd11;
  localparam logic [4:0] PH_AK0  = 5'd12;
  localparam logic [4:0] PH_AK1  = 5'd13;
  localparam logic [4:0] PH_POLL = 5'd14;
  localparam logic [4:0] PH_RLO  = 5'd15;
  localparam logic [4:0] PH_RHI  = 5'd16;
  localparam logic [4:0] PH_KLO  = 5'd17;
  localparam logic [4:0] PH_KHI  = 5'd18;
  localparam logic [4:0] PH_KEND = 5'd19;

  logic [4:0] phase, phase_next;
  logic [3:0] bit_count, bit_count_next;
  logic [7:0] shift_reg, shift_reg_next;
  logic [7:0] poll_count, poll_count_next;
  logic [7:0] hold_count, hold_count_next;
  logic [1:0] line_levels, line_levels_next;
  logic [7:0] rx_hold, rx_hold_next;
  logic [4:0] target;
  logic       do_enter;
  logic       done;
  logic       err;
  logic [7:0] hold_inc;
  logic [2:0] bits_inc;

  // Line levels {scl, sda} set on entry to a phase
  function automatic logic [1:0] levels_for(input logic [4:0] ph, input logic msb,
                                            input logic ab, input logic [1:0] cur);
    logic [1:0] lv;
    case (ph)
      PH_ST0:                   lv = 2'b11;
      PH_ST1:                   lv = 2'b10;
      PH_ST2:                   lv = 2'b00;
      PH_SP0, PH_ESP0:          lv = 2'b00;
      PH_SP1, PH_ESP1:          lv = 2'b10;
      PH_SP2, PH_ESP2:          lv = 2'b11;
      PH_WLO:                   lv = {1'b0, msb};
      PH_WHI:                   lv = {1'b1, msb};
      PH_AK0:                   lv = 2'b01;
      PH_AK1, PH_POLL:          lv = 2'b11;
      PH_RLO:                   lv = 2'b01;
      PH_RHI:                   lv = 2'b11;
      PH_KLO, PH_KEND:          lv = {1'b0, ab};
      PH_KHI:                   lv = {1'b1, ab};
      default:                  lv = cur;
    endcase
    return lv;
  endfunction

  assign hold_inc = hold_count + 8'd1;
  assign bits_inc = bit_count[2:0] + 3'd1;

  // Work out the next phase and the result for one beat
  always_comb begin
    phase_next       = phase;
    bit_count_next   = bit_count;
    shift_reg_next   = shift_reg;
    poll_count_next  = poll_count;
    hold_count_next  = hold_count;
    line_levels_next = line_levels;
    rx_hold_next     = rx_hold;
    target           = phase;
    do_enter         = 1'b0;
    done             = 1'b0;
    err              = 1'b0;

    if (phase == PH_IDLE) begin
      // Take a command; ticks just drive the held levels
      if (op.kind != KIND_TICK) begin
        bit_count_next = 4'd0;
        do_enter       = 1'b1;
        case (op.kind)
          KIND_START: target = PH_ST0;
          KIND_STOP:  target = PH_SP0;
          KIND_WRITE: begin
            shift_reg_next = op.data_byte;
            target         = PH_WLO;
          end
          KIND_READ: begin
            shift_reg_next = 8'd0;
            bit_count_next = {op.send_ack, 3'b000};
            target         = PH_RLO;
          end
          default: do_enter = 1'b0;
        endcase
      end
    end else if (phase == PH_POLL) begin
      // Poll for the acknowledge, once per tick
      if (!op.sda_in) begin
        line_levels_next = 2'b01;
        phase_next       = PH_IDLE;
        done             = 1'b1;
      end else if (poll_count >= cfg.ack_timeout) begin
        target   = PH_ESP0;
        do_enter = 1'b1;
      end else begin
        poll_count_next = poll_count + 8'd1;
      end
    end else begin
      // Hold the phase, then advance
      hold_count_next = hold_inc;
      if (hold_inc >= cfg.phase_ticks) begin
        hold_count_next = 8'd0;
        do_enter        = 1'b1;
        case (phase)
          PH_ST0:  target = PH_ST1;
          PH_ST1:  target = PH_ST2;
          PH_SP0:  target = PH_SP1;
          PH_SP1:  target = PH_SP2;
          PH_ESP0: target = PH_ESP1;
          PH_ESP1: target = PH_ESP2;
          PH_ESP2: begin
            do_enter   = 1'b0;
            phase_next = PH_IDLE;
            done       = 1'b1;
            err        = 1'b1;
          end
          PH_WLO:  target = PH_WHI;
          PH_WHI: begin
            shift_reg_next = {shift_reg[6:0], 1'b0};
            bit_count_next = {bit_count[3], bits_inc};
            target         = (bit_count[2:0] == 3'd7) ? PH_AK0 : PH_WLO;
          end
          PH_AK0:  target = PH_AK1;
          PH_AK1: begin
            poll_count_next = 8'd0;
            target          = PH_POLL;
          end
          PH_RLO:  target = PH_RHI;
          PH_RHI: begin
            shift_reg_next = {shift_reg[6:0], op.sda_in};
            bit_count_next = {bit_count[3], bits_inc};
            target         = (bit_count[2:0] == 3'd7) ? PH_KLO : PH_RLO;
          end
          PH_KLO:  target = PH_KHI;
          PH_KHI:  target = PH_KEND;
          PH_KEND: begin
            do_enter     = 1'b0;
            rx_hold_next = shift_reg;
            phase_next   = PH_IDLE;
            done         = 1'b1;
          end
          default: begin
            // end of start or stop sequence
            do_enter   = 1'b0;
            phase_next = PH_IDLE;
            done       = 1'b1;
          end
        endcase
      end
    end

    if (do_enter) begin
      phase_next       = target;
      hold_count_next  = 8'd0;
      line_levels_next = levels_for(target, shift_reg_next[7], ~bit_count_next[3],
                                    line_levels);
    end
  end

  // Result for this beat: levels driven during it, status after it.
  // A command taken while idle drives its first phase's levels on its own beat.
  always_comb begin
    res.scl       = (phase == PH_IDLE) ? line_levels_next[1] : line_levels[1];
    res.sda       = (phase == PH_IDLE) ? line_levels_next[0] : line_levels[0];
    res.busy_res  = (phase_next != PH_IDLE);
    res.done_res  = done;
    res.ack_error = err;
    res.rx_byte   = rx_hold_next;
  end

  // Update sequencer state on each beat
  always_ff @(posedge clk) begin
    if (rst) begin
      phase       <= PH_IDLE;
      bit_count   <= 4'd0;
      shift_reg   <= 8'd0;
      poll_count  <= 8'd0;
      hold_count  <= 8'd0;
      line_levels <= 2'b11;
      rx_hold     <= 8'd0;
    end else if (step) begin
      phase       <= phase_next;
      bit_count   <= bit_count_next;
      shift_reg   <= shift_reg_next;
      poll_count  <= poll_count_next;
      hold_count  <= hold_count_next;
      line_levels <= line_levels_next;
      rx_hold     <= rx_hold_next;
    end
  end

endmodule

### hdl/i2c_master_bit_engine.sv
// Top level of the I2C master bit engine: queues, front, engine and registers.
//
//   channel   direction  handshake             payload
//   cmd       in         push / full           cmd_item_t (func, data_byte, send_ack, sda_in)
//   res       out        pop / empty           res_item_t (scl, sda, busy, done, ack_error, rx)
//   apb       in/out     psel/penable/pready   paddr[2:0], pwdata, prdata (32 bit)
//
// One result per beat; a beat can enter every cycle while full is low. A beat passes
// the front decode into the op queue, and the engine retires one op per cycle whenever
// the result queue has room; each beat is registered in the op queue and then in the
// result queue. rst is synchronous and empties both queues. When pop stays low the
// result queue fills, the engine holds, and full rises once the op queue fills too.
module i2c_master_bit_engine
  import i2cm_pkg::*;
#(
  parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        push,
  output logic        full,
  input  cmd_item_t   cmd,
  input  logic        pop,
  output logic        empty,
  output res_item_t   res,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  op_item_t  op_front;
  op_item_t  op_back;
  logic      op_empty;
  logic      res_full;
  logic      step;
  res_item_t res_back;
  cfg_t      cfg;
  logic      cfg_wr;

  // Classify incoming beats
  i2cm_front u_front (
    .cmd (cmd),
    .op  (op_front)
  );

  // Queue classified ops between front and engine
  i2cm_fifo #(
    .WIDTH ($bits(op_item_t)),
    .DEPTH (QUEUE_DEPTH)
  ) u_op_q (
    .clk   (clk),
    .rst   (rst),
    .push  (push),
    .wdata (op_front),
    .full  (full),
    .pop   (step),
    .rdata (op_back),
    .empty (op_empty)
  );

  // Retire one op when a result slot is free
  assign step = !op_empty && !res_full;

  i2cm_engine u_engine (
    .clk  (clk),
    .rst  (rst),
    .cfg  (cfg),
    .step (step),
    .op   (op_back),
    .res  (res_back)
  );

  // Hold results until the consumer takes them
  i2cm_fifo #(
    .WIDTH ($bits(res_item_t)),
    .DEPTH (QUEUE_DEPTH)
  ) u_res_q (
    .clk   (clk),
    .rst   (rst),
    .push  (step),
    .wdata (res_back),
    .full  (res_full),
    .pop   (pop),
    .rdata (res),
    .empty (empty)
  );

  // Configuration registers
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.phase_ticks <= PHASE_TICKS_RST;
      cfg.ack_timeout <= ACK_TIMEOUT_RST;
    end else if (cfg_wr) begin
      if (paddr[2] == REG_PHASE_TICKS) begin
        cfg.phase_ticks <= pwdata[7:0];
      end else begin
        cfg.ack_timeout <= pwdata[7:0];
      end
    end
  end

  always_comb begin
    case (paddr[2])
      REG_PHASE_TICKS: prdata = {24'd0, cfg.phase_ticks};
      REG_ACK_TIMEOUT: prdata = {24'd0, cfg.ack_timeout};
      default:         prdata = 32'd0;
    endcase
  end

  // The engine never writes into a full result queue
  a_no_res_overflow: assert property (@(posedge clk) disable iff (rst)
    step |-> !res_full)
    else $error("engine stepped with result queue full");

  // A retired op always leaves a result waiting
  a_step_gives_result: assert property (@(posedge clk) disable iff (rst)
    step |=> !empty)
    else $error("engine step produced no waiting result");

  // Reset leaves both queues empty
  a_reset_empty: assert property (@(posedge clk)
    rst |=> (empty && !full))
    else $error("queues not empty after reset");

endmodule
